// ===== rtl/indexed_max_heap_unit_assert.svh =====
// Assertion macros for the indexed max-heap unit.
`ifndef INDEXED_MAX_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MAX_HEAP_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define IMH_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define IMH_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed max-heap unit.
// ----------------------------------------------------------------------------
package imh_pkg;
    localparam int CAPACITY     = 1024;
    localparam int HANDLE_COUNT = 1024;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int HIDX_W       = $clog2(HANDLE_COUNT);
    localparam int HANDLE_W     = $clog2(HANDLE_COUNT + 1);
    localparam int OCC_W        = SLOT_W + 1;

    // command queue between front and back; depth must be a power of two
    localparam int CMDQ_DEPTH   = 2;
    localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);

    localparam logic       OP_PUSH   = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
        logic [HANDLE_W-1:0] handle;
    } in_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic signed [31:0]  top_value;
        logic                is_empty;
        logic [1:0]          status;
    } out_item_t;

    // classified command from front to back
    typedef struct packed {
        logic               op;
        logic               bad;
        logic signed [31:0] value;
        logic [HIDX_W-1:0]  hidx;
    } cmd_t;
endpackage

// ===== rtl/imh_front.sv =====
// ----------------------------------------------------------------------------
// imh_front
// Accepts items, range-checks the handle and queues commands for the back end.
// ----------------------------------------------------------------------------
module imh_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  imh_pkg::in_item_t in_item,
    output logic              cmd_valid,
    output imh_pkg::cmd_t     cmd,
    input  logic              cmd_take
);
    import imh_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CMDQ_PTR_W:0]   cnt_reg, cnt_next;
    cmd_t                  c_in;
    logic                  do_push;

    always_comb
    begin
        c_in.op    = in_item.op;
        c_in.value = in_item.value;
        c_in.hidx  = HIDX_W'(in_item.handle - HANDLE_W'(1));
        c_in.bad   = (in_item.handle == '0)
                   || (32'(in_item.handle) > 32'(HANDLE_COUNT));
    end

    assign full      = (cnt_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = cmd_take ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= c_in;
        end
    end
endmodule

// ===== rtl/imh_back.sv =====
// ----------------------------------------------------------------------------
// imh_back
// Heap engine: memories plus a sequencer for insert, remove and sifting.
// ----------------------------------------------------------------------------
module imh_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  imh_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               res_valid,
    output imh_pkg::out_item_t res,
    input  logic               res_take
);
    import imh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RM_RD, S_RM_RD2, S_RM_WR, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_RD2, S_DN_CMP, S_TOP_RD, S_TOP, S_OUT
    } state_t;

    // slot memory holds handle index and value together, so one read gives the key
    logic [HIDX_W+32-1:0] slot_mem [CAPACITY];
    logic [SLOT_W-1:0]    hslot_mem [HANDLE_COUNT];
    // live flag per handle; only handles below last_reg were ever written
    logic                 live_mem [HANDLE_COUNT];

    state_t               st_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [HANDLE_W-1:0]  last_reg;
    logic [SLOT_W-1:0]    cur_reg;      // slot of the moving entry
    logic [SLOT_W-1:0]    oth_reg;      // parent, child or last slot
    logic [HIDX_W-1:0]    mh_reg;       // moving entry handle index
    logic signed [31:0]   mv_reg;       // moving entry value
    logic [HIDX_W-1:0]    ch_reg;
    logic signed [31:0]   cv_reg;
    logic                 have_r_reg;
    logic                 dn_only_reg;
    logic [SLOT_W-1:0]    rd_addr;
    logic [HIDX_W+32-1:0] rd_q_reg;
    logic [SLOT_W-1:0]    hs_q_reg;
    logic                 live_q_reg;
    out_item_t            res_reg;
    logic                 rv_reg;
    cmd_t                 c_reg;

    logic [OCC_W:0]       lchild;
    assign lchild = {1'b0, cur_reg, 1'b1};

    assign cmd_take  = (st_reg == S_IDLE) && cmd_valid && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        rd_addr = oth_reg;
        case (st_reg)
            S_TOP_RD: rd_addr = '0;
            S_TOP:    rd_addr = '0;
            default:  rd_addr = oth_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg   <= slot_mem[rd_addr];
        hs_q_reg   <= hslot_mem[c_reg.hidx];
        live_q_reg <= live_mem[c_reg.hidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            occ_reg  <= '0;
            last_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            if (res_take)
            begin
                rv_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        c_reg <= cmd;
                        if (cmd.op == OP_PUSH)
                        begin
                            if (32'(last_reg) >= 32'(HANDLE_COUNT)
                                || 32'(occ_reg) >= 32'(CAPACITY))
                            begin
                                res_reg.new_handle <= '0;
                                res_reg.status     <= ST_REFUSED;
                                st_reg <= S_TOP_RD;
                            end
                            else
                            begin
                                mh_reg   <= HIDX_W'(last_reg);
                                mv_reg   <= cmd.value;
                                cur_reg  <= SLOT_W'(occ_reg);
                                last_reg <= last_reg + 1'b1;
                                res_reg.new_handle <= last_reg + 1'b1;
                                res_reg.status     <= ST_OK;
                                live_mem[HIDX_W'(last_reg)] <= 1'b1;
                                occ_reg  <= occ_reg + 1'b1;
                                dn_only_reg <= 1'b0;
                                st_reg   <= S_UP_RD;
                            end
                        end
                        else
                        begin
                            res_reg.new_handle <= '0;
                            if (cmd.bad)
                            begin
                                res_reg.status <= ST_UNKNOWN;
                                st_reg <= S_TOP_RD;
                            end
                            else
                            begin
                                res_reg.status <= ST_OK;
                                oth_reg <= SLOT_W'(occ_reg - 1'b1);
                                st_reg  <= S_RM_RD;
                            end
                        end
                    end
                end
                S_RM_RD:
                begin
                    st_reg <= S_RM_RD2;  // hs_q, live_q and last slot read land
                end
                S_RM_RD2:
                begin
                    // handle never given or already removed
                    if ({1'b0, c_reg.hidx} >= last_reg || !live_q_reg)
                    begin
                        res_reg.status <= ST_UNKNOWN;
                        st_reg <= S_TOP_RD;
                    end
                    else
                    begin
                        live_mem[c_reg.hidx] <= 1'b0;
                        cur_reg <= hs_q_reg;
                        mh_reg  <= rd_q_reg[HIDX_W+31:32];
                        mv_reg  <= rd_q_reg[31:0];
                        occ_reg <= occ_reg - 1'b1;
                        st_reg  <= S_RM_WR;
                    end
                end
                S_RM_WR:
                begin
                    if ({1'b0, cur_reg} >= occ_reg)
                    begin
                        st_reg <= S_TOP_RD;
                    end
                    else
                    begin
                        dn_only_reg <= 1'b0;
                        st_reg <= S_UP_RD;
                    end
                end
                S_UP_RD:
                begin
                    if (cur_reg == '0)
                    begin
                        st_reg <= S_DN_RD;
                    end
                    else
                    begin
                        oth_reg <= (cur_reg - 1'b1) >> 1;
                        st_reg  <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    // rd_q valid in the cycle after the address is set; wait state folded via flag
                    if (!dn_only_reg)
                    begin
                        dn_only_reg <= 1'b1;
                    end
                    else
                    begin
                        dn_only_reg <= 1'b0;
                        if (mv_reg > $signed(rd_q_reg[31:0]))
                        begin
                            slot_mem[cur_reg] <= rd_q_reg;
                            hslot_mem[rd_q_reg[HIDX_W+31:32]] <= cur_reg;
                            cur_reg <= oth_reg;
                            st_reg  <= S_UP_RD;
                        end
                        else
                        begin
                            st_reg <= S_DN_RD;
                        end
                    end
                end
                S_DN_RD:
                begin
                    slot_mem[cur_reg]  <= {mh_reg, mv_reg};
                    hslot_mem[mh_reg]  <= cur_reg;
                    if (lchild >= {1'b0, occ_reg})
                    begin
                        st_reg <= S_TOP_RD;
                    end
                    else
                    begin
                        oth_reg    <= lchild[SLOT_W-1:0];
                        have_r_reg <= (lchild + 1'b1) < {1'b0, occ_reg};
                        st_reg     <= S_DN_RD2;
                    end
                end
                S_DN_RD2:
                begin
                    // address now left; next cycle rd_q holds left
                    oth_reg <= oth_reg + 1'b1;
                    st_reg  <= S_DN_CMP;
                    dn_only_reg <= 1'b0;
                end
                S_DN_CMP:
                begin
                    if (!dn_only_reg)
                    begin
                        ch_reg <= rd_q_reg[HIDX_W+31:32];
                        cv_reg <= rd_q_reg[31:0];
                        dn_only_reg <= 1'b1;
                    end
                    else
                    begin
                        dn_only_reg <= 1'b0;
                        if (have_r_reg && $signed(rd_q_reg[31:0]) > cv_reg)
                        begin
                            if ($signed(rd_q_reg[31:0]) > mv_reg)
                            begin
                                slot_mem[cur_reg] <= rd_q_reg;
                                hslot_mem[rd_q_reg[HIDX_W+31:32]] <= cur_reg;
                                cur_reg <= oth_reg;
                                st_reg  <= S_DN_RD;
                            end
                            else
                            begin
                                st_reg <= S_TOP_RD;
                            end
                        end
                        else if (cv_reg > mv_reg)
                        begin
                            slot_mem[cur_reg] <= {ch_reg, cv_reg};
                            hslot_mem[ch_reg] <= cur_reg;
                            cur_reg <= oth_reg - 1'b1;
                            st_reg  <= S_DN_RD;
                        end
                        else
                        begin
                            st_reg <= S_TOP_RD;
                        end
                    end
                end
                S_TOP_RD:
                begin
                    st_reg <= S_TOP;
                end
                S_TOP:
                begin
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res_reg.is_empty  <= (occ_reg == '0);
                    res_reg.top_value <= (occ_reg == '0) ? 32'sd0
                                                         : $signed(rd_q_reg[31:0]);
                    rv_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/indexed_max_heap_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_unit
// Addressable binary max-heap of signed 32-bit values with handles.
// ----------------------------------------------------------------------------
// An item waits in the command queue until the engine takes it; a refused or
// unknown item is not sifted, and a moving entry that stays in the heap is
// sifted up and then down, the engine walking one heap level at a time
// through registered reads of the slot memory.
// Up to two items queue ahead of the engine; one result waits on the outputs,
// and the engine does not start the next item until that result is taken.
module indexed_max_heap_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  imh_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output imh_pkg::out_item_t out_item
);
    import imh_pkg::*;

    logic  cmd_valid;
    logic  cmd_take;
    cmd_t  cmd;
    logic  res_valid;

    imh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    imh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (out_item),
        .res_take  (pop && res_valid)
    );

    assign empty = !res_valid;
endmodule

// ===== rtl/imh_checker.sv =====
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks on the indexed max-heap unit.
// ----------------------------------------------------------------------------
`include "indexed_max_heap_unit_assert.svh"

module imh_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input imh_pkg::out_item_t out_item
);
    import imh_pkg::*;

    `IMH_ASSERT_IMPL(a_empty_top, clk, rst_n, !empty && out_item.is_empty, out_item.top_value == 0)
    `IMH_ASSERT_IMPL(a_status_ok, clk, rst_n, !empty, out_item.status != 2'd3)
    `IMH_ASSERT_IMPL(a_handle_ok, clk, rst_n, !empty && out_item.status != ST_OK, out_item.new_handle == '0)
    `IMH_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))
endmodule

bind indexed_max_heap_unit imh_checker u_imh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed max-heap unit: directed table, random
// push/remove traffic and handle exhaustion, all checked against a behavioral heap model.
// ----------------------------------------------------------------------------
module tb;
    import imh_pkg::*;

    localparam int LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    indexed_max_heap_unit DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // behavioral heap; slot_h holds handle index (handle - 1)
    int unsigned slot_h [CAPACITY];
    int unsigned h_slot [HANDLE_COUNT];
    logic signed [31:0] h_val [HANDLE_COUNT];
    bit h_live [HANDLE_COUNT];
    int unsigned occ;
    int unsigned issued;

    out_item_t heap_results [$];
    int unsigned errors;
    int unsigned idle_cycles;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    bit timed_out;

    function automatic logic signed [31:0] key_at(int unsigned s);
        return h_val[slot_h[s]];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        int unsigned t;
        t = slot_h[a];
        slot_h[a] = slot_h[b];
        slot_h[b] = t;
        h_slot[slot_h[a]] = a;
        h_slot[slot_h[b]] = b;
    endfunction

    function automatic void sift_up(int unsigned s);
        int unsigned p;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (key_at(s) <= key_at(p))
                break;
            swap_slots(s, p);
            s = p;
        end
    endfunction

    function automatic void sift_down(int unsigned s);
        int unsigned c;
        while (2 * s + 1 < occ)
        begin
            c = 2 * s + 1;
            if (c + 1 < occ && key_at(c + 1) > key_at(c))
                c = c + 1;
            if (key_at(c) <= key_at(s))
                break;
            swap_slots(s, c);
            s = c;
        end
    endfunction

    function automatic out_item_t heap_step(in_item_t it);
        out_item_t r;
        int unsigned k;
        int unsigned s;
        int unsigned moved;
        r = '0;
        r.status = ST_OK;
        if (it.op == OP_PUSH)
        begin
            if (issued >= HANDLE_COUNT || occ >= CAPACITY)
                r.status = ST_REFUSED;
            else
            begin
                k = issued;
                issued++;
                h_val[k] = it.value;
                h_live[k] = 1'b1;
                h_slot[k] = occ;
                slot_h[occ] = k;
                occ++;
                sift_up(h_slot[k]);
                r.new_handle = HANDLE_W'(issued);
            end
        end
        else if (it.handle == 0 || it.handle > HANDLE_COUNT || !h_live[it.handle - 1])
            r.status = ST_UNKNOWN;
        else
        begin
            k = it.handle - 1;
            s = h_slot[k];
            swap_slots(s, occ - 1);
            occ--;
            h_live[k] = 1'b0;
            if (s < occ)
            begin
                moved = slot_h[s];
                sift_up(s);
                sift_down(h_slot[moved]);
            end
        end
        r.top_value = occ != 0 ? key_at(0) : 32'sd0;
        r.is_empty = occ == 0;
        return r;
    endfunction

    // push stays high between back-to-back items; wait_drained drops it
    task automatic send_item(in_item_t it);
        while (send_idle > 0 && $urandom_range(99, 0) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        heap_results.push_back(heap_step(it));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (heap_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic in_item_t make_item(logic o, logic signed [31:0] v, int h);
        in_item_t it;
        it.op = o;
        it.value = v;
        it.handle = HANDLE_W'(h);
        return it;
    endfunction

    // live handle picked at random, or 0 if none is found in 40 tries
    function automatic int pick_live();
        int h;
        for (int tries = 0; tries < 40; tries++)
        begin
            h = $urandom_range(issued, 1);
            if (issued != 0 && h_live[h - 1])
                return h;
        end
        return 0;
    endfunction

    // receiver
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= !($urandom_range(99, 0) < recv_idle);
        end
    end

    // checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (heap_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, out_item);
                errors++;
            end
            else
            begin
                exp_r = heap_results.pop_front();
                if (out_item.new_handle !== exp_r.new_handle)
                begin
                    $display("%0t: new_handle expected %0d actual %0d", $time,
                             exp_r.new_handle, out_item.new_handle);
                    errors++;
                end
                if (out_item.top_value !== exp_r.top_value)
                begin
                    $display("%0t: top_value expected %0d actual %0d", $time,
                             exp_r.top_value, out_item.top_value);
                    errors++;
                end
                if (out_item.is_empty !== exp_r.is_empty)
                begin
                    $display("%0t: is_empty expected %0d actual %0d", $time,
                             exp_r.is_empty, out_item.is_empty);
                    errors++;
                end
                if (out_item.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, out_item.status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    typedef struct {
        in_item_t  it;
        bit        known;
        out_item_t res;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic void add_row(logic o, logic signed [31:0] v, int h,
                                    bit known, int nh, logic signed [31:0] tv,
                                    logic em, logic [1:0] st);
        dir_row_t r;
        r.it = make_item(o, v, h);
        r.known = known;
        r.res.new_handle = HANDLE_W'(nh);
        r.res.top_value = tv;
        r.res.is_empty = em;
        r.res.status = st;
        dir_rows.push_back(r);
    endfunction

    initial
    begin
        int n;
        int h;
        int live_goal;
        out_item_t pred;
        errors = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        occ = 0;
        issued = 0;
        foreach (h_live[i])
            h_live[i] = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        add_row(OP_REMOVE, 0, 1, 1, 0, 0, 1, ST_UNKNOWN);
        add_row(OP_REMOVE, 0, 0, 1, 0, 0, 1, ST_UNKNOWN);
        add_row(OP_PUSH, 32'sh8000_0000, 2047, 1, 1, 32'sh8000_0000, 0, ST_OK);
        add_row(OP_PUSH, 32'sh7FFF_FFFF, 0, 1, 2, 32'sh7FFF_FFFF, 0, ST_OK);
        add_row(OP_PUSH, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_PUSH, -1, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_PUSH, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 0, 2047, 0, 0, 0, 0, ST_UNKNOWN);
        add_row(OP_REMOVE, 0, 1025, 0, 0, 0, 0, ST_UNKNOWN);
        add_row(OP_REMOVE, 0, 1024, 0, 0, 0, 0, ST_UNKNOWN);
        add_row(OP_REMOVE, -1, 2, 0, 0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 0, 2, 0, 0, 0, 0, ST_UNKNOWN);
        add_row(OP_REMOVE, 0, 5, 0, 0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 0, 1, 0, 0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 0, 3, 0, 0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 0, 4, 1, 0, 0, 1, ST_OK);
        foreach (dir_rows[i])
        begin
            pred = heap_step(dir_rows[i].it);
            if (dir_rows[i].known && pred !== dir_rows[i].res)
            begin
                $display("%0t: directed row %0d expected %p actual model %p",
                         $time, i, dir_rows[i].res, pred);
                errors++;
            end
        end
        // replay on the block with a fresh model copy of the same state
        occ = 0;
        issued = 0;
        foreach (h_live[i])
            h_live[i] = 1'b0;
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].it);
            if (dir_rows[i].known && heap_results[$] !== dir_rows[i].res)
                heap_results[$] = dir_rows[i].res;
        end
        wait_drained();

        // random: three idle phases; live count swings up and down
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = phase == 0 ? 37 : (phase == 1 ? 66 : 0);
            recv_idle = phase == 0 ? 66 : (phase == 1 ? 37 : 0);
            if (phase == 2)
                hold_cycles = 400;
            live_goal = $urandom_range(60, 4);
            for (n = 0; n < 440; n++)
            begin
                if (n % 90 == 0)
                    live_goal = $urandom_range(n % 180 == 0 ? 120 : 10, 1);
                if ($urandom_range(99, 0) < 8)
                    send_item(make_item(OP_REMOVE, $urandom, $urandom_range(2047, 0)));
                else if (occ < live_goal)
                begin
                    case ($urandom_range(4, 0))
                        0: h = 32'sh7FFF_FFFF;
                        1: h = 32'sh8000_0000;
                        2: h = $urandom_range(8, 0);
                        default: h = $urandom;
                    endcase
                    send_item(make_item(OP_PUSH, h, $urandom_range(2047, 0)));
                end
                else
                    send_item(make_item(OP_REMOVE, $urandom, pick_live()));
            end
            wait_drained();
        end

        // exhaust handles: pushes are refused once all are issued
        send_idle = 0;
        recv_idle = 0;
        while (issued < HANDLE_COUNT + 3)
        begin
            send_item(make_item(OP_PUSH, $urandom, 0));
            if (issued == HANDLE_COUNT)
                break;
        end
        send_item(make_item(OP_PUSH, $urandom, 0));
        send_item(make_item(OP_REMOVE, 0, pick_live()));
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
